>>> rtl/bna_pkg.sv
// Package for the batch norm affine unit: widths, codes, register indexes.
// No dependencies.
`default_nettype none
package bna_pkg;
    localparam int MaxFeatures = 64;
    localparam int IdxW        = $clog2(MaxFeatures);
    localparam int DataW       = 32;

    localparam logic [1:0] OP_FWD  = 2'd0;
    localparam logic [1:0] OP_BWD  = 2'd1;
    localparam logic [1:0] OP_UPD  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VAR   = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_MINVAR = 2'd1;
    localparam logic [1:0] REG_LRATE  = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic [5:0]              feature_index;
        logic signed [31:0]      sample;
        logic signed [31:0]      mean_value;
        logic [30:0]             var_value;
        logic signed [31:0]      grad_out;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic signed [31:0] second_value;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [16:0] data;
    } cfg_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (v > hi)
                sat32 = 32'sh7FFFFFFF;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[31:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/bna_if.sv
// Valid/ready channel interfaces for items and configuration writes.
// Depends on bna_pkg.
`default_nettype none
interface bna_in_if (input wire logic clk);
    logic               valid;
    logic               ready;
    bna_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bna_out_if (input wire logic clk);
    logic               valid;
    logic               ready;
    bna_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bna_cfg_if (input wire logic clk);
    logic               valid;
    logic               ready;
    bna_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bna_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bna_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> rtl/bna_divider.sv
// Signed restoring divider: 66-bit dividend by 33-bit positive divisor,
// quotient truncated toward zero, one bit per cycle. Depends on bna_pkg.
`default_nettype none
module bna_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [65:0] dividend,
    input  wire logic [32:0]        divisor,
    output logic                    done,
    output logic signed [65:0]      quotient
);
    import bna_pkg::*;

    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [64:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [33:0] trial;
    logic [33:0] shifted;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg[32:0], quo_reg[64]};
        trial     = shifted - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            neg_next  = dividend[65];
            quo_next  = dividend[65] ? 65'(-dividend) : dividend[64:0];
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial;
                quo_next = {quo_reg[63:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[63:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd64)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done     = busy_reg && (cnt_reg == 7'd64);
    assign quotient = neg_reg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
endmodule
`default_nettype wire

>>> rtl/batch_norm_affine_unit.sv
// Top level of the batch norm affine unit: sequencer, parameter memories,
// square root and multiplier. Depends on bna_pkg, bna_if, bna_ram, bna_divider.
//
// Usage:
//   in_ch  : one transaction per item (operation, index, sample, mean,
//            variance, output gradient).
//   out_ch : one transaction per item (result, second value, status).
//   cfg_ch : register writes, index 0 active_features, 1 min_variance,
//            2 learn_rate; always ready; write only while idle.
// Sequencing: an item is worked on alone. Errors and updates use neither the
// square root nor the divider; forward runs a 24-step bit-pair square root,
// then one pass of a 65-step bit-serial divider, and backward the square root
// and two divider passes. The memories are read in the READ state, which
// follows accept.
// Reset: gamma memory holds one, beta and both accumulators zero; this is
// given by a per-entry written bit per memory group, cleared by reset.
// Stall: the result sits in the output register; the next item is not
// taken until the result transaction completes.
`default_nettype none
module batch_norm_affine_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    bna_in_if.sink    in_ch,
    bna_out_if.source out_ch,
    bna_cfg_if.sink   cfg_ch
);
    import bna_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_DIV1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_DIV2  = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_WRITE = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_UPD2  = 4'd11;

    logic [3:0]   state_reg, state_next;
    logic [6:0]   active_reg;
    logic [16:0]  minvar_reg;
    logic [16:0]  lrate_reg;
    in_item_t     item_reg;
    out_item_t    res_reg, res_next;
    logic [MaxFeatures-1:0] par_wr_reg, acc_wr_reg;

    logic         par_we, acc_we;
    logic [63:0]  par_wdata, acc_wdata, par_rdata, acc_rdata;
    logic signed [31:0] gamma, beta, gacc, bacc;
    logic signed [31:0] gamma_reg, beta_reg, gacc_reg, bacc_reg;
    logic signed [31:0] new_g_reg, new_b_reg, new_gacc_reg, new_bacc_reg;

    // square root
    logic [47:0]  sq_n_reg;
    logic [47:0]  sq_res_reg;
    logic [47:0]  sq_bit_reg;
    logic [32:0]  root_reg;
    logic [47:0]  sq_sum;

    // multiplier and divider
    logic signed [65:0] prod_reg;
    logic signed [32:0] diff_reg;
    logic               div_start;
    logic               div_done;
    logic signed [65:0] quo;

    assign gamma = par_wr_reg[item_reg.feature_index] ? $signed(par_rdata[63:32])
                                                       : 32'sd65536;
    assign beta  = par_wr_reg[item_reg.feature_index] ? $signed(par_rdata[31:0]) : 32'sd0;
    assign gacc  = acc_wr_reg[item_reg.feature_index] ? $signed(acc_rdata[63:32]) : 32'sd0;
    assign bacc  = acc_wr_reg[item_reg.feature_index] ? $signed(acc_rdata[31:0]) : 32'sd0;

    bna_ram #(.Width(64), .Depth(MaxFeatures)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .addr  (item_reg.feature_index),
        .wdata (par_wdata),
        .rdata (par_rdata)
    );

    bna_ram #(.Width(64), .Depth(MaxFeatures)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .addr  (item_reg.feature_index),
        .wdata (acc_wdata),
        .rdata (acc_rdata)
    );

    bna_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (root_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = res_reg;

    assign par_we    = (state_reg == S_WRITE) && (item_reg.operation == OP_UPD);
    assign acc_we    = (state_reg == S_WRITE) && (item_reg.operation == OP_BWD);
    assign par_wdata = {new_g_reg, new_b_reg};
    assign acc_wdata = {new_gacc_reg, new_bacc_reg};
    assign sq_sum    = sq_res_reg + sq_bit_reg;
    assign div_start = (state_reg == S_MUL1) || (state_reg == S_MUL2);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                    state_next = S_READ;
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                res_next = '0;
                if (item_reg.operation == OP_NONE)
                    state_next = S_OUT;
                else if ({1'b0, item_reg.feature_index} >= active_reg)
                begin
                    res_next.status = ST_INDEX;
                    state_next      = S_OUT;
                end
                else if (item_reg.operation == OP_UPD)
                    state_next = S_UPD;
                else if (item_reg.var_value < 31'(minvar_reg))
                begin
                    res_next.status = ST_VAR;
                    state_next      = S_OUT;
                end
                else
                    state_next = S_SQRT;
            end
            S_SQRT:
                if (sq_bit_reg == '0)
                    state_next = S_MUL1;
            S_MUL1:
                state_next = S_DIV1;
            S_DIV1:
                if (div_done)
                begin
                    if (item_reg.operation == OP_FWD)
                    begin
                        res_next.result_value = sat32(66'(quo) + 66'(beta_reg));
                        state_next = S_OUT;
                    end
                    else
                    begin
                        res_next.result_value = sat32(quo);
                        state_next = S_MUL2;
                    end
                end
            S_MUL2:
                state_next = S_DIV2;
            S_DIV2:
                if (div_done)
                    state_next = S_WRITE;
            S_UPD:
                state_next = S_UPD2;
            S_UPD2:
            begin
                res_next.result_value = new_g_reg;
                res_next.second_value = new_b_reg;
                state_next = S_WRITE;
            end
            S_WRITE:
                state_next = S_OUT;
            S_OUT:
                if (out_ch.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 7'd64;
            minvar_reg <= 17'd1;
            lrate_reg  <= 17'd655;
            par_wr_reg <= '0;
            acc_wr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                case (cfg_ch.data.index)
                    REG_ACTIVE: active_reg <= cfg_ch.data.data[6:0];
                    REG_MINVAR: minvar_reg <= cfg_ch.data.data;
                    REG_LRATE:  lrate_reg  <= cfg_ch.data.data;
                    default:    ;
                endcase
            end
            if (par_we)
                par_wr_reg[item_reg.feature_index] <= 1'b1;
            if (acc_we)
                acc_wr_reg[item_reg.feature_index] <= 1'b1;
        end
    end

    logic signed [33:0] lm_g, lm_b;
    logic signed [49:0] upd_g_prod, upd_b_prod;
    assign upd_g_prod = $signed({1'b0, lrate_reg}) * gacc_reg;
    assign upd_b_prod = $signed({1'b0, lrate_reg}) * bacc_reg;
    assign lm_g = 34'(upd_g_prod >>> 16);
    assign lm_b = 34'(upd_b_prod >>> 16);

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == S_IDLE && in_ch.valid)
            item_reg <= in_ch.data;
        if (state_reg == S_CHECK)
        begin
            gamma_reg <= gamma;
            beta_reg  <= beta;
            gacc_reg  <= gacc;
            bacc_reg  <= bacc;
            diff_reg  <= 33'(item_reg.sample) - 33'(item_reg.mean_value);
            sq_n_reg  <= {32'(item_reg.var_value) + 32'(minvar_reg), 16'd0};
            sq_res_reg <= '0;
            sq_bit_reg <= 48'h4000_0000_0000;
        end
        if (state_reg == S_SQRT)
        begin
            if (sq_bit_reg != '0)
            begin
                if (sq_n_reg >= sq_sum)
                begin
                    sq_n_reg   <= sq_n_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            else
            begin
                root_reg <= (sq_res_reg == '0) ? 33'd1 : sq_res_reg[32:0];
                prod_reg <= (item_reg.operation == OP_FWD)
                          ? 66'(gamma_reg * diff_reg)
                          : 66'(item_reg.grad_out * gamma_reg);
            end
        end
        if (state_reg == S_DIV1 && div_done)
            prod_reg <= 66'(item_reg.grad_out * diff_reg);
        if (state_reg == S_DIV2 && div_done)
        begin
            new_gacc_reg <= sat32(66'(gacc_reg) + ((quo > 66'sd1099511627776) ?
                            66'sd1099511627776 : (quo < -66'sd1099511627776) ?
                            -66'sd1099511627776 : quo));
            new_bacc_reg <= sat32(66'(bacc_reg) + 66'(item_reg.grad_out));
        end
        if (state_reg == S_UPD)
        begin
            new_g_reg <= sat32(66'(gamma_reg) - 66'(lm_g));
            new_b_reg <= sat32(66'(beta_reg) - 66'(lm_b));
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == S_READ)
        else $error("accepted item did not start read");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(par_we && acc_we))
        else $error("both memories written at once");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(res_reg))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for batch_norm_affine_unit: directed table, then random phases under
// several register settings, every result checked against a table value or an in-bench predictor.
// Depends on bna_pkg, bna_if and the RTL of the block.
`timescale 1ns / 1ps
module tb;
    import bna_pkg::*;

    localparam int PhaseItems = 155;
    localparam int CycleLimit = 3000000;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bna_in_if  in_ch (clk);
    bna_out_if out_ch (clk);
    bna_cfg_if cfg_ch (clk);

    batch_norm_affine_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    logic signed [31:0] gamma_mem [MaxFeatures];
    logic signed [31:0] beta_mem [MaxFeatures];
    logic signed [31:0] gamma_grad [MaxFeatures];
    logic signed [31:0] beta_grad [MaxFeatures];
    logic [6:0]         n_active;
    logic [16:0]        var_floor;
    logic [16:0]        step_rate;

    out_item_t   pending_results [$];
    stim_row_t   dir_table [$];
    int          fails;
    int          n_accepted;
    int          cycles;
    logic        hold_off;
    int          stall_left;
    int          free_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim_lo,
                                                   input logic signed [63:0] lim_hi);
        if (v < lim_lo)
            return lim_lo;
        if (v > lim_hi)
            return lim_hi;
        return v;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = clamp_q(v, -64'sd2147483648, 64'sd2147483647);
        return c[31:0];
    endfunction

    function automatic logic [63:0] root_of(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return (res == 0) ? 64'd1 : res;
    endfunction

    function automatic out_item_t predict_norm(input in_item_t it);
        out_item_t          o;
        logic signed [63:0] x, m, g, diff, gam, r, q, t, lr, acc, upd;
        logic [63:0]        n;
        int                 k;
        o = '0;
        k = it.feature_index;
        x = it.sample;
        m = it.mean_value;
        g = it.grad_out;
        if (it.operation == OP_NONE)
            o = '0;
        else if ({1'b0, it.feature_index} >= n_active)
            o.status = ST_INDEX;
        else if (it.operation == OP_UPD)
        begin
            lr = $signed({47'd0, step_rate});
            acc = gamma_grad[k];
            upd = gamma_mem[k] - ((lr * acc) >>> 16);
            gamma_mem[k] = clip32(upd);
            acc = beta_grad[k];
            upd = beta_mem[k] - ((lr * acc) >>> 16);
            beta_mem[k] = clip32(upd);
            o.result_value = gamma_mem[k];
            o.second_value = beta_mem[k];
        end
        else if (it.var_value < {14'd0, var_floor})
            o.status = ST_VAR;
        else
        begin
            n = ({33'd0, it.var_value} + {47'd0, var_floor}) << 16;
            r = $signed(root_of(n));
            diff = x - m;
            gam = gamma_mem[k];
            if (it.operation == OP_FWD)
            begin
                q = clamp_q((gam * diff) / r, -(64'sd1 <<< 40), 64'sd1 <<< 40);
                o.result_value = clip32(q + beta_mem[k]);
            end
            else
            begin
                t = clamp_q((g * diff) / r, -(64'sd1 <<< 40), 64'sd1 <<< 40);
                o.result_value = clip32((g * gam) / r);
                gamma_grad[k] = clip32(gamma_grad[k] + t);
                beta_grad[k] = clip32(beta_grad[k] + g);
            end
        end
        return o;
    endfunction

    function automatic in_item_t mk(input logic [1:0] op, input int idx,
                                    input logic [31:0] x, input logic [31:0] m,
                                    input logic [30:0] v, input logic [31:0] g);
        in_item_t it;
        it.operation = op;
        it.feature_index = idx[5:0];
        it.sample = x;
        it.mean_value = m;
        it.var_value = v;
        it.grad_out = g;
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input bit typed,
                                    input logic signed [31:0] r1,
                                    input logic signed [31:0] r2, input logic [1:0] st);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.want.result_value = r1;
        row.want.second_value = r2;
        row.want.status = st;
        dir_table.push_back(row);
    endfunction

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int       r;
        it.sample = rand_word();
        it.mean_value = rand_word();
        it.grad_out = rand_word();
        r = $urandom_range(0, 19);
        it.operation = (r < 8) ? OP_FWD : (r < 16) ? OP_BWD : (r < 19) ? OP_UPD : OP_NONE;
        if ($urandom_range(0, 9) == 0)
            it.feature_index = 6'($urandom_range(0, 63));
        else
            it.feature_index = 6'($urandom_range(0, n_active - 1));
        case ($urandom_range(0, 5))
            0: it.var_value = (var_floor > 0) ? 31'(var_floor - 17'd1) : 31'd0;
            1: it.var_value = 31'(var_floor);
            2: it.var_value = 31'd0;
            3: it.var_value = 31'($urandom_range(0, 32'h0010_0000));
            default: it.var_value = 31'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        int        r;
        int        gap;
        out_item_t got;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        got = predict_norm(it);
        pending_results.push_back(typed ? want : got);
        n_accepted++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= '{index: idx, data: val};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_ACTIVE: n_active = val[6:0];
            REG_MINVAR: var_floor = val;
            default:    step_rate = val;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(input int act, input int mv, input int lr);
        wait_drained();
        write_reg(REG_ACTIVE, act[16:0]);
        write_reg(REG_MINVAR, mv[16:0]);
        write_reg(REG_LRATE, lr[16:0]);
    endtask

    // receiver: random stalls, free-running stretches, long hold-off
    always @(posedge clk)
    begin
        int r;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off)
            out_ch.ready <= 1'b0;
        else if (free_left > 0)
        begin
            free_left--;
            out_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                stall_left = $urandom_range(20, 80);
            else if (r < 25)
                stall_left = $urandom_range(1, 3);
            else if (r > 97)
                free_left = 200;
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        hold_off <= 1'b0;
        while (n_accepted < 400)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_ch.data);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.data.result_value !== want.result_value)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             want.result_value, out_ch.data.result_value);
                    fails++;
                end
                if (out_ch.data.second_value !== want.second_value)
                begin
                    $display("%0t: second_value expected %h actual %h", $time,
                             want.second_value, out_ch.data.second_value);
                    fails++;
                end
                if (out_ch.data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_ch.data.status);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        out_item_t none;
        none = '0;
        fails = 0;
        n_accepted = 0;
        cycles = 0;
        stall_left = 0;
        free_left = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        for (int i = 0; i < MaxFeatures; i++)
        begin
            gamma_mem[i] = 32'sd65536;
            beta_mem[i] = 0;
            gamma_grad[i] = 0;
            beta_grad[i] = 0;
        end
        n_active = 7'd64;
        var_floor = 17'd1;
        step_rate = 17'd655;

        add_row(mk(OP_FWD, 0, 0, 0, 0, 0), 1, 0, 0, ST_VAR);
        add_row(mk(OP_NONE, 7, 32'h1234, 0, 5, 9), 1, 0, 0, ST_OK);
        add_row(mk(OP_UPD, 5, 0, 0, 0, 0), 1, 32'sd65536, 0, ST_OK);
        add_row(mk(OP_FWD, 0, 32'd65536, 0, 31'd65535, 0), 1, 32'sd65536, 0, ST_OK);
        add_row(mk(OP_FWD, 63, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 0), 0, 0, 0, 0);
        add_row(mk(OP_FWD, 63, 32'h80000000, 32'h7FFFFFFF, 31'd65535, 0), 0, 0, 0, 0);
        add_row(mk(OP_BWD, 1, 32'h7FFFFFFF, 32'h80000000, 31'd65535, 32'h7FFFFFFF),
                0, 0, 0, 0);
        add_row(mk(OP_BWD, 1, 32'h80000000, 32'h7FFFFFFF, 31'd0, 32'h80000000), 0, 0, 0, 0);
        add_row(mk(OP_BWD, 1, 32'h80000000, 32'h7FFFFFFF, 31'd1, 32'h80000000), 0, 0, 0, 0);
        add_row(mk(OP_UPD, 1, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(OP_BWD, 2, 32'd1000, 0, 0, 32'd5000), 1, 0, 0, ST_VAR);
        add_row(mk(OP_FWD, 3, 32'h0003_0000, 32'hFFFF_0000, 31'h7FFFFFFF, 0), 0, 0, 0, 0);
        add_row(mk(OP_UPD, 3, 0, 0, 0, 0), 1, 32'sd65536, 0, ST_OK);
        add_row(mk(OP_NONE, 63, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF),
                1, 0, 0, ST_OK);
        add_row(mk(OP_BWD, 63, 32'h0002_8000, 32'h0000_4000, 31'h0001_0000, 32'h0000_8000),
                0, 0, 0, 0);
        add_row(mk(OP_UPD, 63, 0, 0, 0, 0), 0, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_regs(1, 0, 0);
                1: set_regs(64, 65536, 65536);
                5: set_regs(64, 1, 655);
                default: set_regs($urandom_range(1, 64), $urandom_range(0, 65536),
                                  $urandom_range(0, 65536));
            endcase
            repeat (PhaseItems)
                send_item(rand_item(), 0, none);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/bna_pkg.sv
rtl/bna_if.sv
rtl/bna_ram.sv
rtl/bna_divider.sv
rtl/batch_norm_affine_unit.sv
tb/tb.sv
